[rtl/rounded_rect_fill_blend_defines.svh]
// Assertion macros shared by the rounded-rectangle fill blend RTL.
`ifndef ROUNDED_RECT_FILL_BLEND_DEFINES_SVH
`define ROUNDED_RECT_FILL_BLEND_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RRFB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define RRFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rrfb_pkg.sv]
// Package with the shared constants and register codes of the rounded-rectangle fill blend.
package rrfb_pkg;

  localparam int unsigned CoordWidthDef = 12;
  localparam int unsigned AddrWidth     = 24;
  localparam int unsigned PixelWidth    = 32;
  localparam int unsigned DataWidth     = 32;
  localparam int unsigned PaddrWidth    = 5;
  localparam int unsigned RegIdxWidth   = 3;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned BlendSumWidth = 17;

  localparam logic [2:0]            BlendOps    = 3'd6;
  localparam logic [ByteWidth-1:0]  AlphaOpaque = 8'hFF;
  localparam logic [ByteWidth-1:0]  AlphaClear  = 8'h00;
  localparam logic [PixelWidth-1:0] OpaqueMask  = 32'hFF00_0000;

  typedef enum logic [RegIdxWidth-1:0] {
    REG_RECT_LEFT     = 3'd0,
    REG_RECT_TOP      = 3'd1,
    REG_RECT_WIDTH    = 3'd2,
    REG_RECT_HEIGHT   = 3'd3,
    REG_CORNER_RADIUS = 3'd4,
    REG_FILL_COLOR    = 3'd5,
    REG_ROW_STRIDE    = 3'd6
  } reg_idx_e;

endpackage

[rtl/rrfb_mul.sv]
// Shared unsigned multiplier with a registered product.
module rrfb_mul #(
  parameter int unsigned OP_WIDTH = rrfb_pkg::CoordWidthDef + 1
) (
  input  logic                  clk_i,
  input  logic [OP_WIDTH-1:0]   a_i,
  input  logic [OP_WIDTH-1:0]   b_i,
  output logic [2*OP_WIDTH-1:0] p_o
);

  logic [2*OP_WIDTH-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= {{OP_WIDTH{1'b0}}, a_i} * {{OP_WIDTH{1'b0}}, b_i};
  end

  assign p_o = p_q;

endmodule

[rtl/rrfb_sqrt.sv]
// Iterative floor square root, one root bit per cycle.
module rrfb_sqrt #(
  parameter int unsigned ROOT_WIDTH = rrfb_pkg::CoordWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [2*ROOT_WIDTH-1:0] value_i,
  output logic [ROOT_WIDTH-1:0]   root_o,
  output logic                    done_o
);

  localparam int unsigned VW   = 2 * ROOT_WIDTH;
  localparam int unsigned CNTW = $clog2(ROOT_WIDTH + 1);

  logic [VW-1:0]         n_q;
  logic [ROOT_WIDTH:0]   rem_q;
  logic [ROOT_WIDTH-1:0] root_q;
  logic [CNTW-1:0]       cnt_q;
  logic                  done_q;

  logic [ROOT_WIDTH+2:0] cur_w;
  logic [ROOT_WIDTH+2:0] trial_w;
  logic [ROOT_WIDTH+2:0] diff_w;
  logic                  take_w;

  // Bring down the next two bits and try the next root bit.
  assign cur_w   = {rem_q, n_q[VW-1 -: 2]};
  assign trial_w = {1'b0, root_q, 2'b01};
  assign diff_w  = cur_w - trial_w;
  assign take_w  = (cur_w >= trial_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNTW'(ROOT_WIDTH);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      n_q    <= {n_q[VW-3:0], 2'b00};
      rem_q  <= take_w ? diff_w[ROOT_WIDTH:0] : cur_w[ROOT_WIDTH:0];
      root_q <= {root_q[ROOT_WIDTH-2:0], take_w};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

[rtl/rounded_rect_fill_blend.sv]
// Top level of the rounded-rectangle fill shader with alpha blending.
//
// Usage: each input transaction on the in channel (in_valid_i / in_stall_o)
// carries one framebuffer pixel: its column, its row and its current ARGB8888
// value. Each produces exactly one output transaction on the out channel
// (out_valid_o / out_stall_i) with the pixel address (row * stride + column,
// modulo 2^24), a write flag that is set when the pixel lies inside the
// rounded rectangle, and the new pixel value.
// The geometry and fill colour are set through the APB-style register port;
// the user must set them only while the block is idle, which the block itself
// does not enforce. Registers sit at byte address 4 * index.
// The block handles one pixel at a time; the next pixel can be taken in the
// cycle after the result enters the output register. The pace is set by the
// square-root unit, which resolves one root bit per cycle. The squares, the
// address product and the blend products go through one shared multiplier;
// the blend products are formed while the root iterates.
// The result sits in an output register, so the block is free again as soon
// as that register can take it; while the receiver stalls, a waiting result
// holds and the next finished result waits in the final step.
// Reset clears the sequencer and the output valid, and sets the registers to
// zero except the row stride, which comes up at 2^COORD_WIDTH.
`include "rounded_rect_fill_blend_defines.svh"

module rounded_rect_fill_blend #(
  parameter int unsigned COORD_WIDTH = rrfb_pkg::CoordWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Pixel input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [COORD_WIDTH-1:0]           pixel_x_i,
  input  logic [COORD_WIDTH-1:0]           pixel_y_i,
  input  logic [rrfb_pkg::PixelWidth-1:0]  dst_pixel_i,
  // Result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [rrfb_pkg::AddrWidth-1:0]   pixel_addr_o,
  output logic                             write_enable_o,
  output logic [rrfb_pkg::PixelWidth-1:0]  out_pixel_o,
  // Register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rrfb_pkg::PaddrWidth-1:0]  paddr,
  input  logic [rrfb_pkg::DataWidth-1:0]   pwdata,
  output logic [rrfb_pkg::DataWidth-1:0]   prdata,
  output logic                             pready
);

  import rrfb_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned SW = COORD_WIDTH + 1;   // size and stride width
  localparam int unsigned MW = SW;                // multiplier operand width
  localparam int unsigned PW = 2 * MW;            // product width
  localparam int unsigned RW = 2 * CW;            // radicand width
  localparam int unsigned EW = (PW > AddrWidth) ? PW : AddrWidth;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RR,
    S_DD,
    S_ADDR,
    S_BLEND,
    S_WAIT,
    S_FIN
  } state_e;

  // Configuration registers
  logic [CW-1:0]         rect_left_q;
  logic [CW-1:0]         rect_top_q;
  logic [SW-1:0]         rect_width_q;
  logic [SW-1:0]         rect_height_q;
  logic [CW-1:0]         corner_radius_q;
  logic [PixelWidth-1:0] fill_color_q;
  logic [SW-1:0]         row_stride_q;

  logic     cfg_wr;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[PaddrWidth-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_left_q     <= '0;
      rect_top_q      <= '0;
      rect_width_q    <= '0;
      rect_height_q   <= '0;
      corner_radius_q <= '0;
      fill_color_q    <= '0;
      row_stride_q    <= SW'(1) << CW;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RECT_LEFT:     rect_left_q     <= pwdata[CW-1:0];
        REG_RECT_TOP:      rect_top_q      <= pwdata[CW-1:0];
        REG_RECT_WIDTH:    rect_width_q    <= pwdata[SW-1:0];
        REG_RECT_HEIGHT:   rect_height_q   <= pwdata[SW-1:0];
        REG_CORNER_RADIUS: corner_radius_q <= pwdata[CW-1:0];
        REG_FILL_COLOR:    fill_color_q    <= pwdata;
        REG_ROW_STRIDE:    row_stride_q    <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RECT_LEFT:     prdata = DataWidth'(rect_left_q);
      REG_RECT_TOP:      prdata = DataWidth'(rect_top_q);
      REG_RECT_WIDTH:    prdata = DataWidth'(rect_width_q);
      REG_RECT_HEIGHT:   prdata = DataWidth'(rect_height_q);
      REG_CORNER_RADIUS: prdata = DataWidth'(corner_radius_q);
      REG_FILL_COLOR:    prdata = fill_color_q;
      REG_ROW_STRIDE:    prdata = DataWidth'(row_stride_q);
      default:           prdata = '0;
    endcase
  end

  // Radius clamped to half the smaller side; depends on registers only.
  logic [SW-1:0] min_side_w;
  logic [CW-1:0] max_r_w;
  logic [CW-1:0] radius_w;

  assign min_side_w = (rect_width_q < rect_height_q) ? rect_width_q : rect_height_q;
  assign max_r_w    = min_side_w[SW-1:1];
  assign radius_w   = (corner_radius_q > max_r_w) ? max_r_w : corner_radius_q;

  // Sequencer and working registers
  state_e state_q;
  logic [2:0] cnt_q;

  logic [CW-1:0]         px_q;
  logic [CW-1:0]         py_q;
  logic [PixelWidth-1:0] dst_q;
  logic [CW-1:0]         r_q;
  logic [CW-1:0]         dy_q;
  logic                  band_q;
  logic                  rows_ok_q;
  logic [RW-1:0]         rr_q;
  logic [AddrWidth-1:0]  addr_q;
  logic [15:0]           acc_q;
  logic [ByteWidth-1:0]  ch_q [3];

  logic                  out_valid_q;
  logic [AddrWidth-1:0]  out_addr_q;
  logic                  out_we_q;
  logic [PixelWidth-1:0] out_pixel_q;
  logic                  out_load;

  // Shared multiplier
  logic [MW-1:0] mul_a;
  logic [MW-1:0] mul_b;
  logic [PW-1:0] mul_p;

  rrfb_mul #(
    .OP_WIDTH (MW)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Square-root unit
  logic          sqrt_start;
  logic [RW-1:0] sqrt_value;
  logic [CW-1:0] sqrt_root;
  logic          sqrt_done;

  assign sqrt_start = (state_q == S_ADDR);
  assign sqrt_value = rr_q - mul_p[RW-1:0];

  rrfb_sqrt #(
    .ROOT_WIDTH (CW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (sqrt_value),
    .root_o  (sqrt_root),
    .done_o  (sqrt_done)
  );

  // Row geometry: distance from the top row and from the bottom row.
  logic [SW-1:0] dy_top_w;
  logic [SW-1:0] dy_bot_w;
  logic [SW-1:0] dist_w;
  logic [SW-1:0] dy_w;
  logic          top_band_w;
  logic          bot_band_w;
  logic          rows_ok_w;

  assign dy_top_w   = SW'(py_q) - SW'(rect_top_q);
  assign dy_bot_w   = rect_height_q - SW'(1) - dy_top_w;
  assign top_band_w = (dy_top_w < SW'(r_q));
  assign bot_band_w = (dy_bot_w < SW'(r_q));
  assign dist_w     = top_band_w ? dy_top_w : dy_bot_w;
  assign dy_w       = SW'(r_q) - dist_w;
  assign rows_ok_w  = (rect_width_q != '0) && (rect_height_q != '0) &&
                      (py_q >= rect_top_q) && (dy_top_w < rect_height_q);

  // Blend operands: even steps take fill byte times alpha, odd steps
  // take destination byte times the inverse alpha.
  logic [ByteWidth-1:0] alpha_w;
  logic [ByteWidth-1:0] inv_alpha_w;
  logic [1:0]           op_ch_w;
  logic [4:0]           op_sh_w;
  logic [2:0]           prod_idx_w;
  logic [BlendSumWidth-1:0] blend_sum_w;

  assign alpha_w     = fill_color_q[PixelWidth-1 -: ByteWidth];
  assign inv_alpha_w = AlphaOpaque - alpha_w;
  assign op_ch_w     = cnt_q[2:1];
  assign op_sh_w     = {op_ch_w, 3'b000};
  assign prod_idx_w  = cnt_q - 3'd1;
  assign blend_sum_w = BlendSumWidth'(acc_q) + BlendSumWidth'(mul_p[15:0]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_RR: begin
        mul_a = MW'(r_q);
        mul_b = MW'(r_q);
      end
      S_DD: begin
        mul_a = MW'(dy_q);
        mul_b = MW'(dy_q);
      end
      S_ADDR: begin
        mul_a = MW'(py_q);
        mul_b = row_stride_q;
      end
      S_BLEND: begin
        if (cnt_q < BlendOps) begin
          if (!cnt_q[0]) begin
            mul_a = MW'(fill_color_q[op_sh_w +: ByteWidth]);
            mul_b = MW'(alpha_w);
          end else begin
            mul_a = MW'(dst_q[op_sh_w +: ByteWidth]);
            mul_b = MW'(inv_alpha_w);
          end
        end
      end
      default: ;
    endcase
  end

  // Final coverage test: the span shrinks by r - dx on each side in the
  // corner bands.
  logic [CW-1:0]         off_w;
  logic [CW-1:0]         dxp_w;
  logic [SW-1:0]         span_end_w;
  logic                  covered_w;
  logic [PixelWidth-1:0] blended_w;
  logic [EW-1:0]         prod_ext_w;

  assign off_w      = band_q ? (r_q - sqrt_root) : '0;
  assign dxp_w      = px_q - rect_left_q;
  assign span_end_w = SW'(dxp_w) + SW'(off_w);
  assign covered_w  = rows_ok_q && (px_q >= rect_left_q) && (dxp_w >= off_w) &&
                      (span_end_w < rect_width_q);
  assign prod_ext_w = EW'(mul_p);

  always_comb begin
    if (alpha_w == AlphaClear) begin
      blended_w = dst_q;
    end else if (alpha_w == AlphaOpaque) begin
      blended_w = fill_color_q | OpaqueMask;
    end else begin
      blended_w = {AlphaOpaque, ch_q[2], ch_q[1], ch_q[0]};
    end
  end

  // Load the output register from the final step once it is free or being emptied.
  assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  // State, counter and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_addr_q  <= '0;
      out_we_q    <= 1'b0;
      out_pixel_q <= '0;
    end else begin
      // Take the new result, or drop the old one once the receiver takes it.
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_addr_q  <= addr_q;
        out_we_q    <= covered_w;
        out_pixel_q <= covered_w ? blended_w : dst_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_RR;
          end
        end
        S_RR:   state_q <= S_DD;
        S_DD:   state_q <= S_ADDR;
        S_ADDR: begin
          cnt_q   <= '0;
          state_q <= S_BLEND;
        end
        S_BLEND: begin
          if (cnt_q == BlendOps) begin
            cnt_q   <= '0;
            state_q <= S_WAIT;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        S_WAIT: begin
          if (sqrt_done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          // Hold until the output register is free or being emptied.
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Working registers, no reset needed.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          px_q  <= pixel_x_i;
          py_q  <= pixel_y_i;
          dst_q <= dst_pixel_i;
          r_q   <= radius_w;
        end
      end
      S_RR: begin
        dy_q      <= dy_w[CW-1:0];
        band_q    <= top_band_w || bot_band_w;
        rows_ok_q <= rows_ok_w;
      end
      S_DD: rr_q <= mul_p[RW-1:0];
      S_BLEND: begin
        if (cnt_q == '0) begin
          addr_q <= prod_ext_w[AddrWidth-1:0] + AddrWidth'(px_q);
        end else if (!prod_idx_w[0]) begin
          acc_q <= mul_p[15:0];
        end else begin
          ch_q[prod_idx_w[2:1]] <= blend_sum_w[15:8];
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign pixel_addr_o   = out_addr_q;
  assign write_enable_o = out_we_q;
  assign out_pixel_o    = out_pixel_q;

  `RRFB_ASSERT_NOW(a_fin_has_root, state_q == S_FIN, sqrt_done,
    "final step reached before the root is ready")
  `RRFB_ASSERT_NEXT(a_fin_holds_on_stall, state_q == S_FIN && out_valid_q && out_stall_i,
    state_q == S_FIN, "result left the final step while the output was blocked")
  `RRFB_ASSERT_NOW(a_load_from_fin, $rose(out_valid_q), $past(state_q == S_FIN),
    "output register loaded outside the final step")

endmodule

[bench/tb_rounded_rect_fill_blend.sv]
// Self-checking testbench for the rounded-rectangle fill blend shader.
`timescale 1ns / 1ps

module tb_rounded_rect_fill_blend;
  import rrfb_pkg::*;

  localparam int CW            = CoordWidthDef;
  localparam int CoordMax      = (1 << CW) - 1;
  localparam int SizeMax       = 1 << CW;
  localparam int ReportLimit   = 10;
  localparam int QuietLimit    = 4000;  // cycles without any transaction
  localparam int SettleCycles  = CW + 8;
  localparam int PhaseCount    = 26;
  localparam int ItemsPerPhase = 51;
  localparam int HoldPhase     = 6;
  localparam int HoldCycles    = 300;
  localparam int PausePhase    = 11;

  // Index past the last register; writes to it must change nothing.
  localparam logic [RegIdxWidth-1:0] UnusedRegIdx = 3'd7;

  typedef struct packed {
    logic [AddrWidth-1:0]  addr;
    logic                  we;
    logic [PixelWidth-1:0] pix;
  } pixel_result_t;

  // Shadow of the register file plus the queue of pixel writes still owed by the block.
  class fill_result_board;
    logic [CW-1:0]         left, top, radius;
    logic [CW:0]           width, height, stride;
    logic [PixelWidth-1:0] color;
    pixel_result_t         expected_q[$];
    int                    mismatches;

    function new();
      left       = '0;
      top        = '0;
      width      = '0;
      height     = '0;
      radius     = '0;
      color      = '0;
      stride     = SizeMax;
      mismatches = 0;
    endfunction

    function void set_reg(logic [RegIdxWidth-1:0] idx, logic [DataWidth-1:0] value);
      case (idx)
        REG_RECT_LEFT:     left   = value[CW-1:0];
        REG_RECT_TOP:      top    = value[CW-1:0];
        REG_RECT_WIDTH:    width  = value[CW:0];
        REG_RECT_HEIGHT:   height = value[CW:0];
        REG_CORNER_RADIUS: radius = value[CW-1:0];
        REG_FILL_COLOR:    color  = value[PixelWidth-1:0];
        REG_ROW_STRIDE:    stride = value[CW:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_pixel(logic [CW-1:0] px, logic [CW-1:0] py, logic [PixelWidth-1:0] dst);
      pixel_result_t res;
      longint qx, qy, full_addr, x0, y0, x1, y1, r, dy, rem, dx, step, sx0, sx1;
      bit hit;
      int a, s, d, mix;
      qx = px;
      qy = py;
      full_addr = qy * longint'(stride) + qx;
      res.addr = full_addr[AddrWidth-1:0];

      hit = 1'b0;
      if (width != 0 && height != 0) begin
        x0 = left;
        y0 = top;
        x1 = x0 + longint'(width) - 1;
        y1 = y0 + longint'(height) - 1;
        r = (width < height ? longint'(width) : longint'(height)) / 2;
        if (longint'(radius) < r) r = radius;
        sx0 = x0;
        sx1 = x1;
        // Corner bands: the span narrows by r minus the floor root of r^2 - dy^2.
        if (qy <= y0 + r - 1 || qy > y1 - r) begin
          dy  = (qy <= y0 + r - 1) ? (y0 + r - qy) : (qy - (y1 - r));
          rem = r * r - dy * dy;
          if (rem < 0) rem = 0;
          dx = 0;
          for (int b = CW; b >= 0; b--) begin
            step = longint'(1) << b;
            if ((dx + step) * (dx + step) <= rem) dx += step;
          end
          sx0 = x0 + r - dx;
          sx1 = x1 - r + dx;
        end
        hit = (qy >= y0) && (qy <= y1) && (qx >= sx0) && (qx <= sx1);
      end

      res.we  = hit;
      res.pix = dst;
      a = color[PixelWidth-1 -: ByteWidth];
      if (hit && a == int'(AlphaOpaque)) begin
        res.pix = color | OpaqueMask;
      end else if (hit && a != int'(AlphaClear)) begin
        res.pix = OpaqueMask;
        for (int c = 0; c < 3; c++) begin
          s   = color[ByteWidth*c +: ByteWidth];
          d   = dst[ByteWidth*c +: ByteWidth];
          mix = (s * a + d * (int'(AlphaOpaque) - a)) >> ByteWidth;
          res.pix[ByteWidth*c +: ByteWidth] = mix[ByteWidth-1:0];
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_write(logic [AddrWidth-1:0] addr, logic we, logic [PixelWidth-1:0] pix);
      pixel_result_t exp_res;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected pixel result: addr %h we %b pix %h", addr, we, pix);
        return;
      end
      exp_res = expected_q.pop_front();
      if (addr !== exp_res.addr || we !== exp_res.we || pix !== exp_res.pix) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("pixel result mismatch: expected addr %h we %b pix %h, got addr %h we %b pix %h",
                   exp_res.addr, exp_res.we, exp_res.pix, addr, we, pix);
      end
    endfunction
  endclass

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_stall_o;
  logic [CW-1:0]          pixel_x_i      = '0;
  logic [CW-1:0]          pixel_y_i      = '0;
  logic [PixelWidth-1:0]  dst_pixel_i    = '0;
  logic                   out_valid_o;
  logic                   out_stall_i    = 1'b0;
  logic [AddrWidth-1:0]   pixel_addr_o;
  logic                   write_enable_o;
  logic [PixelWidth-1:0]  out_pixel_o;
  logic                   psel           = 1'b0;
  logic                   penable        = 1'b0;
  logic                   pwrite         = 1'b0;
  logic [PaddrWidth-1:0]  paddr          = '0;
  logic [DataWidth-1:0]   pwdata         = '0;
  logic [DataWidth-1:0]   prdata;
  logic                   pready;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  int hold_request  = 0;

  fill_result_board board = new();

  rounded_rect_fill_blend #(
    .COORD_WIDTH(CW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .dst_pixel_i    (dst_pixel_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_addr_o   (pixel_addr_o),
    .write_enable_o (write_enable_o),
    .out_pixel_o    (out_pixel_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #10 clk_i = ~clk_i;

  // Receiver: stall at random, or hold off for a whole stretch on request so that
  // the block backs up into its input channel.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Check every result transaction against the oldest predicted write. Values read
  // right after the edge are the ones the edge sampled.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_write(pixel_addr_o, write_enable_o, out_pixel_o);
  end

  // Watchdog: end the run when no transaction moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // Write one register in a setup phase, an access phase and then an idle phase so
  // that the next write never drives psel twice in one step.
  task automatic write_reg(input logic [RegIdxWidth-1:0] idx, input logic [DataWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setup(input logic [DataWidth-1:0] l, t, w, h, r, c, s);
    write_reg(REG_RECT_LEFT, l);
    write_reg(REG_RECT_TOP, t);
    write_reg(REG_RECT_WIDTH, w);
    write_reg(REG_RECT_HEIGHT, h);
    write_reg(REG_CORNER_RADIUS, r);
    write_reg(REG_FILL_COLOR, c);
    write_reg(REG_ROW_STRIDE, s);
  endtask

  // Offer one pixel, idling at random first; return once the transaction is taken.
  // Valid stays high into the next call so back-to-back pixels leave no gap.
  task automatic offer_pixel(input logic [CW-1:0] x, input logic [CW-1:0] y,
                             input logic [PixelWidth-1:0] dst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pixel_x_i   <= x;
    pixel_y_i   <= y;
    dst_pixel_i <= dst;
    do @(posedge clk_i); while (in_stall_o);
    board.note_pixel(x, y, dst);
  endtask

  // Stop sending, wait for every owed result, then let the pipeline settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Pick a coordinate: mostly around the rectangle and its corner bands, some anywhere.
  function automatic logic [CW-1:0] pick_coord(int lo, int span, int rad);
    int v;
    case ($urandom_range(9))
      0, 1:    return CW'($urandom);
      2, 3:    v = lo + int'($urandom_range(rad + 1)) - 1;
      4, 5:    v = lo + span - int'($urandom_range(rad + 1));
      default: v = lo - 2 + int'($urandom_range(span + 3));
    endcase
    if (v < 0) v = 0;
    if (v > CoordMax) v = CoordMax;
    return CW'(v);
  endfunction

  initial begin : stimulus
    logic [DataWidth-1:0] l, t, w, h, r, c, s;
    int eff_l, eff_t, eff_w, eff_h, eff_r;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: empty rectangle, stride at 2^CW.
    offer_pixel(12'd0, 12'd0, 32'h0000_0000);
    offer_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    offer_pixel(12'd5, 12'd7, 32'h1234_5678);
    drain();

    // Half-transparent fill on a 40x30 box with radius 8; probe the corner
    // bands, the straight edges and the rows just outside.
    apply_setup(100, 50, 40, 30, 8, 32'h8020_4060, 640);
    write_reg(UnusedRegIdx, '1);
    offer_pixel(100, 50, 32'h0000_0000);
    offer_pixel(108, 50, 32'hFFFF_FFFF);
    offer_pixel(107, 50, 32'hA5A5_A5A5);
    offer_pixel(100, 58, 32'hFFFF_FFFF);
    offer_pixel(99, 58, 32'h0102_0304);
    offer_pixel(139, 58, 32'h0000_0000);
    offer_pixel(140, 58, 32'h5A5A_5A5A);
    offer_pixel(120, 79, 32'h00FF_00FF);
    offer_pixel(120, 80, 32'hFF00_FF00);
    offer_pixel(120, 49, 32'h7777_7777);
    drain();

    // Zero fill alpha: covered but unchanged; zero stride gives the column.
    apply_setup(100, 50, 40, 30, 8, 32'h0011_2233, 0);
    offer_pixel(120, 60, 32'h89AB_CDEF);
    offer_pixel(4095, 0, 32'h0000_0001);
    drain();

    // Opaque fill over the whole frame, radius clamped to half a side;
    // oversized stride wraps the address.
    apply_setup(0, 0, SizeMax, SizeMax, CoordMax, 32'hFFAB_CDEF, 32'h0000_1FFF);
    offer_pixel(12'hFFF, 12'hFFF, 32'h1111_1111);
    offer_pixel(2048, 2048, 32'h2222_2222);
    offer_pixel(0, 2048, 32'h3333_3333);
    drain();

    // Zero width covers nothing.
    apply_setup(10, 10, 0, 20, 3, 32'h8000_00FF, 1);
    offer_pixel(10, 15, 32'hDEAD_BEEF);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain();

      case ($urandom_range(9))
        0: begin  // full frame, any radius
          l = 0; t = 0; w = SizeMax; h = SizeMax;
          r = $urandom_range(CoordMax);
        end
        1: begin  // box that runs past the coordinate range
          l = $urandom_range(CoordMax - 64, CoordMax);
          t = $urandom_range(CoordMax - 64, CoordMax);
          w = $urandom_range(1, SizeMax);
          h = $urandom_range(1, SizeMax);
          r = $urandom_range(CoordMax);
        end
        2: begin  // one side empty
          l = $urandom_range(CoordMax); t = $urandom_range(CoordMax);
          w = $urandom_range(1) ? 0 : $urandom_range(1, 40);
          h = (w == 0) ? $urandom_range(0, 40) : 0;
          r = $urandom_range(20);
        end
        3: begin  // one or two pixels thin
          l = $urandom_range(CoordMax); t = $urandom_range(CoordMax);
          w = $urandom_range(1, 2); h = $urandom_range(1, 60);
          if ($urandom_range(1)) begin
            s = w; w = h; h = s;
          end
          r = $urandom_range(3);
        end
        default: begin
          l = $urandom_range(CoordMax); t = $urandom_range(CoordMax);
          w = $urandom_range(1, 80); h = $urandom_range(1, 80);
          r = $urandom_range(45);
        end
      endcase

      case ($urandom_range(3))
        0:       c = {AlphaClear, 24'($urandom)};
        1:       c = {AlphaOpaque, 24'($urandom)};
        default: c = $urandom;
      endcase

      case ($urandom_range(5))
        0:       s = 0;
        1:       s = 1;
        2:       s = SizeMax;
        3:       s = 32'h0000_1FFF;
        default: s = $urandom_range(1, SizeMax);
      endcase

      eff_l = l & CoordMax;
      eff_t = t & CoordMax;
      eff_w = w & (2 * SizeMax - 1);
      eff_h = h & (2 * SizeMax - 1);
      eff_r = r & CoordMax;
      if (eff_r > (eff_w < eff_h ? eff_w : eff_h) / 2) eff_r = (eff_w < eff_h ? eff_w : eff_h) / 2;

      // Now and then load junk above the register widths; it must be dropped.
      if ($urandom_range(7) == 0) begin
        l |= $urandom << 13;
        r |= $urandom << 13;
        s |= $urandom << 13;
      end
      apply_setup(l, t, w, h, r, c, s);

      // Rotate the idling mix; mode zero gives stretches with no gaps at all.
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase

      // Back the block up once while pixels keep coming.
      if (phase == HoldPhase) hold_request = HoldCycles;

      for (int n = 0; n < ItemsPerPhase; n++) begin
        // Pause the sender once mid-phase until every result is back.
        if (phase == PausePhase && n == ItemsPerPhase / 2) drain();
        offer_pixel(pick_coord(eff_l, eff_w, eff_r), pick_coord(eff_t, eff_h, eff_r), $urandom);
      end
    end

    drain();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/rrfb_pkg.sv
rtl/rrfb_mul.sv
rtl/rrfb_sqrt.sv
rtl/rounded_rect_fill_blend.sv
bench/tb_rounded_rect_fill_blend.sv
